[rtl/rpss_pkg.sv]
package rpss_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned TableCount = 7;
  localparam int unsigned RowW       = 16;
  localparam int unsigned TblW       = 3;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned FillW      = $clog2(TableDepth + 1);

  localparam logic [RowW-1:0] RowsPerCycleReset = 16'd123;

  localparam logic [TblW-1:0] TgtRowsPerCycle = 3'd0;
  localparam int unsigned     TblFront        = 4;
  localparam int unsigned     TblBack         = 5;
  localparam int unsigned     TblStop         = 6;

  typedef enum logic [2:0] {
    ActLeft     = 3'd0,
    ActRight    = 3'd1,
    ActClear    = 3'd2,
    ActProgram  = 3'd3,
    ActSetCount = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    SideNone  = 2'd0,
    SideLeft  = 2'd1,
    SideRight = 2'd2
  } side_e;

  typedef enum logic [0:0] {
    StIdle = 1'b0,
    StScan = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]      action;
    logic [2:0]      target;
    logic [RowW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [3:0]      color_drive;
    logic [1:0]      roller_drive;
    logic            stop_pulse;
    logic [RowW-1:0] row_now;
    logic [RowW-1:0] cycles_remaining;
    logic            rejected;
  } res_t;

  typedef struct packed {
    logic                  valid;
    logic [RowW-1:0]       row;
    logic [TableCount-1:0] hits;
  } scan_t;

  typedef struct packed {
    logic            en;
    logic [TblW-1:0] tbl;
    logic [IdxW-1:0] idx;
    logic [RowW-1:0] data;
  } wr_t;

endpackage

[rtl/rpss_cell.sv]
module rpss_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rpss_pkg::IdxW-1:0] cell_idx_i,
  input  logic                     clear_i,
  input  rpss_pkg::wr_t            wr_i,
  input  rpss_pkg::scan_t          scan_i,
  output rpss_pkg::scan_t          scan_o
);

  logic [rpss_pkg::RowW-1:0]       entry_q [rpss_pkg::TableCount];
  logic [rpss_pkg::TableCount-1:0] vld_q;
  logic [rpss_pkg::TableCount-1:0] hit;
  logic                            scan_vld_q;
  logic [rpss_pkg::RowW-1:0]       scan_row_q;
  logic [rpss_pkg::TableCount-1:0] scan_hits_q;

  always_comb begin
    for (int t = 0; t < rpss_pkg::TableCount; t++) begin
      hit[t] = vld_q[t] && (entry_q[t] == scan_i.row);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      vld_q[wr_i.tbl] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      entry_q[wr_i.tbl] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_row_q  <= scan_i.row;
    scan_hits_q <= scan_i.hits | hit;
  end

  assign scan_o = '{valid: scan_vld_q, row: scan_row_q, hits: scan_hits_q};

endmodule

[rtl/rpss_chain.sv]
module rpss_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  rpss_pkg::wr_t   wr_i,
  input  rpss_pkg::scan_t scan_i,
  output rpss_pkg::scan_t scan_o
);

  rpss_pkg::scan_t link [rpss_pkg::TableDepth+1];

  assign link[0] = scan_i;

  for (genvar k = 0; k < rpss_pkg::TableDepth; k++) begin : g_cell
    rpss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (rpss_pkg::IdxW'(k)),
      .clear_i    (clear_i),
      .wr_i       (wr_i),
      .scan_i     (link[k]),
      .scan_o     (link[k+1])
    );
  end

  assign scan_o = link[rpss_pkg::TableDepth];

endmodule

[rtl/row_pattern_solenoid_sequencer_unit.sv]
// Row pattern solenoid sequencer.
// A command is transferred on req_i at a rising edge where start is high and
// busy is low. Each command yields exactly one result on res_o, marked by a
// one-cycle strobe on done_o; the receiver takes it in that cycle and cannot
// stall it.
// Clear, program and set-count commands, and sensor events that are ignored
// or stopped by the cycle countdown, give their result in the cycle after
// the transfer and keep busy low, so a new command can follow at once.
// A left or right sensor event that looks up its row sends the row through a
// chain of TableDepth cells, one cell per cycle, each holding one entry of
// all seven tables. busy stays high while the row passes the cells; once it
// leaves the last cell, busy falls and the result is shown, and the next
// command can be transferred. The chain's length sets how long this takes.
// Reset empties all tables, sets rows per cycle to 123, the current row to 0,
// the upcoming row to 1 and the countdown and solenoid latches to 0.
module row_pattern_solenoid_sequencer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rpss_pkg::req_t req_i,
  output logic           done_o,
  output rpss_pkg::res_t res_o
);

  rpss_pkg::state_e          state_q, state_d;
  rpss_pkg::side_e           side_q, side_d;
  logic [rpss_pkg::RowW-1:0] rpc_q, rpc_d;
  logic [rpss_pkg::RowW-1:0] cur_q, cur_d;
  logic [rpss_pkg::RowW-1:0] up_q, up_d;
  logic [rpss_pkg::RowW-1:0] cnt_q, cnt_d;
  logic [3:0]                color_q, color_d;
  logic [1:0]                roller_q, roller_d;
  logic                      pend_left_q, pend_left_d;
  logic [rpss_pkg::FillW-1:0] fill_q [rpss_pkg::TableCount];
  logic [rpss_pkg::FillW-1:0] fill_d [rpss_pkg::TableCount];
  rpss_pkg::res_t            res_q, res_d;
  logic                      done_q, done_d;

  logic                      accept;
  logic                      launch;
  logic                      imm;
  logic                      stop;
  logic                      rej;
  logic                      clear;
  logic [rpss_pkg::RowW-1:0] cnt_n;
  logic [rpss_pkg::TblW-1:0] tbl;
  rpss_pkg::wr_t             wr;
  rpss_pkg::scan_t           scan_in;
  rpss_pkg::scan_t           scan_out;

  assign accept = start && (state_q == rpss_pkg::StIdle);
  assign tbl    = req_i.target - 3'd1;

  always_comb begin
    side_d      = side_q;
    rpc_d       = rpc_q;
    cur_d       = cur_q;
    up_d        = up_q;
    cnt_d       = cnt_q;
    color_d     = color_q;
    roller_d    = roller_q;
    pend_left_d = pend_left_q;
    fill_d      = fill_q;
    res_d       = res_q;
    done_d      = 1'b0;
    launch      = 1'b0;
    imm         = 1'b0;
    stop        = 1'b0;
    rej         = 1'b0;
    clear       = 1'b0;
    wr          = '0;
    cnt_n       = cnt_q;
    scan_in     = '0;
    if (accept) begin
      imm = 1'b1;
      case (req_i.action)
        rpss_pkg::ActLeft: begin
          if (side_q == rpss_pkg::SideRight) begin
            side_d      = rpss_pkg::SideLeft;
            up_d        = (cur_q < rpc_q) ? cur_q + 16'd1 : 16'd1;
            launch      = 1'b1;
            pend_left_d = 1'b1;
          end
        end
        rpss_pkg::ActRight: begin
          if (side_q != rpss_pkg::SideRight) begin
            if ((cur_q == rpc_q) && (up_q == 16'd1)) begin
              cnt_n = cnt_q - 16'd1;
            end
            cnt_d = cnt_n;
            if (cnt_n == '0) begin
              stop = 1'b1;
            end else begin
              side_d      = rpss_pkg::SideRight;
              cur_d       = up_q;
              launch      = 1'b1;
              pend_left_d = 1'b0;
            end
          end
        end
        rpss_pkg::ActClear: begin
          clear  = 1'b1;
          side_d = rpss_pkg::SideNone;
          rpc_d  = '0;
          cur_d  = '0;
          up_d   = 16'd1;
          cnt_d  = '0;
          for (int t = 0; t < rpss_pkg::TableCount; t++) begin
            fill_d[t] = '0;
          end
        end
        rpss_pkg::ActProgram: begin
          if (req_i.value != '0) begin
            if (req_i.target == rpss_pkg::TgtRowsPerCycle) begin
              rpc_d = req_i.value;
            end else if (fill_q[tbl] == rpss_pkg::FillW'(rpss_pkg::TableDepth)) begin
              rej = 1'b1;
            end else begin
              wr.en       = 1'b1;
              wr.tbl      = tbl;
              wr.idx      = fill_q[tbl][rpss_pkg::IdxW-1:0];
              wr.data     = req_i.value;
              fill_d[tbl] = fill_q[tbl] + 1'b1;
            end
          end
        end
        rpss_pkg::ActSetCount: begin
          cnt_d = req_i.value;
        end
        default: begin
        end
      endcase
      if (launch) begin
        imm           = 1'b0;
        scan_in.valid = 1'b1;
        scan_in.row   = pend_left_d ? up_d : cur_d;
      end
      if (imm) begin
        done_d                 = 1'b1;
        res_d.color_drive      = color_d;
        res_d.roller_drive     = roller_d;
        res_d.stop_pulse       = stop;
        res_d.row_now          = cur_d;
        res_d.cycles_remaining = cnt_d;
        res_d.rejected         = rej;
      end
    end else if ((state_q == rpss_pkg::StScan) && scan_out.valid) begin
      if (pend_left_q) begin
        color_d = scan_out.hits[3:0];
      end else begin
        roller_d = {scan_out.hits[rpss_pkg::TblBack], scan_out.hits[rpss_pkg::TblFront]};
        stop     = scan_out.hits[rpss_pkg::TblStop];
      end
      done_d                 = 1'b1;
      res_d.color_drive      = color_d;
      res_d.roller_drive     = roller_d;
      res_d.stop_pulse       = stop;
      res_d.row_now          = cur_q;
      res_d.cycles_remaining = cnt_q;
      res_d.rejected         = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpss_pkg::StIdle: begin
        if (accept && launch) begin
          state_d = rpss_pkg::StScan;
        end
      end
      rpss_pkg::StScan: begin
        if (scan_out.valid) begin
          state_d = rpss_pkg::StIdle;
        end
      end
      default: begin
        state_d = rpss_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    busy   = (state_q != rpss_pkg::StIdle);
    done_o = done_q;
    res_o  = res_q;
  end

  rpss_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .wr_i    (wr),
    .scan_i  (scan_in),
    .scan_o  (scan_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpss_pkg::StIdle;
      side_q      <= rpss_pkg::SideNone;
      rpc_q       <= rpss_pkg::RowsPerCycleReset;
      cur_q       <= '0;
      up_q        <= 16'd1;
      cnt_q       <= '0;
      color_q     <= '0;
      roller_q    <= '0;
      pend_left_q <= 1'b0;
      done_q      <= 1'b0;
      for (int t = 0; t < rpss_pkg::TableCount; t++) begin
        fill_q[t] <= '0;
      end
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      rpc_q       <= rpc_d;
      cur_q       <= cur_d;
      up_q        <= up_d;
      cnt_q       <= cnt_d;
      color_q     <= color_d;
      roller_q    <= roller_d;
      pend_left_q <= pend_left_d;
      done_q      <= done_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a lookup is still running");

  a_scan_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_out.valid |-> (state_q == rpss_pkg::StScan))
    else $error("lookup result left the chain outside a lookup");

  a_busy_from_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(launch))
    else $error("busy rose without a lookup being launched");
`endif

endmodule

[test/solenoid_drive_checker.sv]
module solenoid_drive_checker
  import rpss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  res_t        res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  logic [RowW-1:0] pat [TableCount][TableDepth];
  int unsigned     fill [TableCount];
  logic [RowW-1:0] rows_per_cycle;
  logic [RowW-1:0] cur_row;
  logic [RowW-1:0] next_row;
  logic [RowW-1:0] countdown;
  side_e           side;
  logic [3:0]      color;
  logic [1:0]      roller;

  res_t expected_drives [$];
  res_t want;
  int unsigned errors = 0;
  int unsigned pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void wipe_program();
    for (int t = 0; t < TableCount; t++) begin
      fill[t] = 0;
      for (int k = 0; k < TableDepth; k++) pat[t][k] = '0;
    end
    rows_per_cycle = '0;
    cur_row        = '0;
    next_row       = 16'd1;
    side           = SideNone;
    countdown      = '0;
  endfunction

  function automatic bit row_listed(int t, logic [RowW-1:0] row);
    for (int k = 0; k < fill[t] && k < TableDepth; k++) begin
      if (pat[t][k] == row) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_drive(req_t cmd);
    res_t drive;
    logic stop_req;
    logic full_hit;
    int   t;
    stop_req = 1'b0;
    full_hit = 1'b0;
    case (cmd.action)
      ActLeft: begin
        if (side == SideRight) begin
          side     = SideLeft;
          next_row = (cur_row < rows_per_cycle) ? cur_row + 16'd1 : 16'd1;
          color    = '0;
          for (int c = 0; c < 4; c++) begin
            if (row_listed(c, next_row)) color[c] = 1'b1;
          end
        end
      end
      ActRight: begin
        if (side != SideRight) begin
          if (cur_row == rows_per_cycle && next_row == 16'd1) countdown = countdown - 16'd1;
          if (countdown == '0) begin
            stop_req = 1'b1;
          end else begin
            side    = SideRight;
            cur_row = next_row;
            roller  = '0;
            if (row_listed(TblFront, cur_row)) roller[0] = 1'b1;
            if (row_listed(TblBack, cur_row)) roller[1] = 1'b1;
            if (row_listed(TblStop, cur_row)) stop_req = 1'b1;
          end
        end
      end
      ActClear: wipe_program();
      ActProgram: begin
        if (cmd.value != '0) begin
          if (cmd.target == TgtRowsPerCycle) begin
            rows_per_cycle = cmd.value;
          end else begin
            t = int'(cmd.target) - 1;
            if (fill[t] >= TableDepth) begin
              full_hit = 1'b1;
            end else begin
              pat[t][fill[t]] = cmd.value;
              fill[t]++;
            end
          end
        end
      end
      ActSetCount: countdown = cmd.value;
      default: ;
    endcase
    drive.color_drive      = color;
    drive.roller_drive     = roller;
    drive.stop_pulse       = stop_req;
    drive.row_now          = cur_row;
    drive.cycles_remaining = countdown;
    drive.rejected         = full_hit;
    return drive;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_program();
      rows_per_cycle = RowsPerCycleReset;
      color          = '0;
      roller         = '0;
      expected_drives.delete();
    end else begin
      if (done_i) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("result transfer with no command waiting");
        end else begin
          want = expected_drives.pop_front();
          if (res_i.color_drive !== want.color_drive)
            report_mismatch($sformatf("color_drive %h, expected %h",
                                      res_i.color_drive, want.color_drive));
          if (res_i.roller_drive !== want.roller_drive)
            report_mismatch($sformatf("roller_drive %h, expected %h",
                                      res_i.roller_drive, want.roller_drive));
          if (res_i.stop_pulse !== want.stop_pulse)
            report_mismatch($sformatf("stop_pulse %b, expected %b",
                                      res_i.stop_pulse, want.stop_pulse));
          if (res_i.row_now !== want.row_now)
            report_mismatch($sformatf("row_now %0d, expected %0d",
                                      res_i.row_now, want.row_now));
          if (res_i.cycles_remaining !== want.cycles_remaining)
            report_mismatch($sformatf("cycles_remaining %0d, expected %0d",
                                      res_i.cycles_remaining, want.cycles_remaining));
          if (res_i.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, expected %b",
                                      res_i.rejected, want.rejected));
        end
      end
      if (start_i && !busy_i) expected_drives.push_back(predict_drive(req_i));
    end
    pending = expected_drives.size();
  end

endmodule

[test/tb.sv]
module tb;
  import rpss_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req   = '0;
  logic        done;
  res_t        res;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;

  int          burst_left = 0;
  int          sent = 0;
  int unsigned span = 10;

  row_pattern_solenoid_sequencer_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .res_o  (res)
  );

  solenoid_drive_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start_i   (start),
    .busy_i    (busy),
    .req_i     (req),
    .done_i    (done),
    .res_i     (res),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Each call returns at the edge where the transfer happened; start stays
  // high when the next command follows inside the same burst.
  task automatic issue(logic [2:0] act, logic [2:0] tgt, logic [RowW-1:0] val);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : int'($urandom_range(1, 16));
    end
    start        <= 1'b1;
    req.action   <= act;
    req.target   <= tgt;
    req.value    <= val;
    do @(posedge clk); while (busy);
    burst_left--;
    sent++;
  endtask

  function automatic logic [RowW-1:0] pick_row();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return RowW'($urandom_range(0, 65535));
    return RowW'($urandom_range(1, (span == 0 ? 10 : span) + 1));
  endfunction

  task automatic stir_noise();
    case ($urandom_range(0, 19))
      0: issue(ActRight, 3'($urandom_range(0, 7)), RowW'($urandom_range(0, 65535)));
      1: issue(ActLeft, 3'($urandom_range(0, 7)), RowW'($urandom_range(0, 65535)));
      2: issue(3'($urandom_range(5, 7)), 3'($urandom_range(0, 7)),
               RowW'($urandom_range(0, 65535)));
      3: issue(ActSetCount, 3'($urandom_range(0, 7)), '0);
      4: issue(ActSetCount, 3'($urandom_range(0, 7)), RowW'($urandom_range(1, 3)));
      5: issue(ActProgram, 3'($urandom_range(1, 7)), pick_row());
      default: ;
    endcase
  endtask

  // One pattern: optional clear, programming, cycle count, then alternating
  // carriage passes with some out-of-order events mixed in.
  task automatic run_session(bit overfill);
    int n;
    int tgt;
    logic [RowW-1:0] count;
    if (overfill || $urandom_range(0, 1))
      issue(ActClear, 3'($urandom_range(0, 7)), RowW'($urandom_range(0, 65535)));
    span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 10);
    issue(ActProgram, TgtRowsPerCycle, RowW'(span));
    n = int'($urandom_range(0, 10));
    repeat (n) issue(ActProgram, 3'($urandom_range(1, 7)), pick_row());
    if (overfill || $urandom_range(0, 5) == 0) begin
      tgt = int'($urandom_range(1, 7));
      repeat ($urandom_range(33, 36)) issue(ActProgram, tgt[2:0], pick_row());
    end
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = RowW'($urandom_range(0, 65535));
      default: count = RowW'($urandom_range(1, 4));
    endcase
    issue(ActSetCount, 3'($urandom_range(0, 7)), count);
    n = int'($urandom_range(3, 16));
    repeat (n) begin
      stir_noise();
      issue(ActRight, 3'($urandom_range(0, 7)), RowW'($urandom_range(0, 65535)));
      stir_noise();
      issue(ActLeft, 3'($urandom_range(0, 7)), RowW'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(ActLeft, 3'd0, '0);
    issue(ActRight, 3'd7, 16'hFFFF);
    issue(ActProgram, TgtRowsPerCycle, '0);
    issue(ActProgram, TgtRowsPerCycle, 16'd1);
    issue(ActProgram, 3'd1, 16'd1);
    issue(ActProgram, 3'd4, 16'd1);
    issue(ActProgram, 3'd5, 16'd1);
    issue(ActProgram, 3'd6, 16'hFFFF);
    issue(ActProgram, 3'd7, 16'd1);
    issue(ActProgram, 3'd7, 16'd1);
    issue(ActSetCount, 3'd0, 16'd1);
    issue(ActRight, 3'd0, '0);
    issue(ActRight, 3'd0, '0);
    issue(ActLeft, 3'd0, '0);
    issue(ActLeft, 3'd0, '0);
    issue(ActRight, 3'd0, '0);
    issue(ActSetCount, 3'd0, '0);
    issue(ActRight, 3'd0, '0);
    issue(3'd5, 3'd0, '0);
    issue(3'd6, 3'd7, 16'hFFFF);
    issue(3'd7, 3'd3, 16'h5A5A);
    issue(ActSetCount, 3'd7, 16'hFFFF);
    issue(ActClear, 3'd0, '0);

    run_session(1'b1);
    while (sent < 700) run_session(1'b0);

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
